// ===== rtl/source_text_tokenizer_defines.svh =====
// Assertion macros for the tokeniser. Each expects clk and rst_n in scope.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define STL_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("source_text_tokenizer: check failed");

`define STL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("source_text_tokenizer: check failed");

`else

`define STL_ASSERT_IMPLIES(label, ante, cons)

`define STL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/stl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int MAX_RESULTS           = 3;
    localparam int FIFO_DEPTH            = 4;
    localparam int TDATA_W               = 40;

    // token kinds
    localparam logic [4:0] K_PLUS    = 5'd0;
    localparam logic [4:0] K_MINUS   = 5'd1;
    localparam logic [4:0] K_STAR    = 5'd2;
    localparam logic [4:0] K_SLASH   = 5'd3;
    localparam logic [4:0] K_NEWLINE = 5'd4;
    localparam logic [4:0] K_END     = 5'd5;
    localparam logic [4:0] K_EQ      = 5'd6;
    localparam logic [4:0] K_EQEQ    = 5'd7;
    localparam logic [4:0] K_GT      = 5'd8;
    localparam logic [4:0] K_GTEQ    = 5'd9;
    localparam logic [4:0] K_LT      = 5'd10;
    localparam logic [4:0] K_LTEQ    = 5'd11;
    localparam logic [4:0] K_NOTEQ   = 5'd12;
    localparam logic [4:0] K_STRING  = 5'd13;
    localparam logic [4:0] K_NUMBER  = 5'd14;
    localparam logic [4:0] K_IDENT   = 5'd15;
    localparam logic [4:0] K_ERROR   = 5'd16;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
    localparam logic [2:0] ERR_BAD_STR  = 3'd2;
    localparam logic [2:0] ERR_BAD_NUM  = 3'd3;
    localparam logic [2:0] ERR_UNTERM   = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG = 3'd5;

    // characters
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_EQ        = 8'h3D;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

    typedef enum logic [11:0] {
        MODE_IDLE    = 12'b0000_0000_0001,
        MODE_COMMENT = 12'b0000_0000_0010,
        MODE_EQ      = 12'b0000_0000_0100,
        MODE_GT      = 12'b0000_0000_1000,
        MODE_LT      = 12'b0000_0001_0000,
        MODE_BANG    = 12'b0000_0010_0000,
        MODE_INT     = 12'b0000_0100_0000,
        MODE_DOT     = 12'b0000_1000_0000,
        MODE_FRAC    = 12'b0001_0000_0000,
        MODE_IDENT   = 12'b0010_0000_0000,
        MODE_STRING  = 12'b0100_0000_0000,
        MODE_DRAIN   = 12'b1000_0000_0000
    } mode_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [2:0]  error_code;
        logic        run_last;
    } token_t;

    // tokens caused by one byte, packed from slot 0
    typedef struct packed {
        token_t [MAX_RESULTS-1:0] tok;
        logic [1:0]               count;
    } result_set_t;

endpackage

`default_nettype wire

// ===== rtl/stl_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stl_scan #(
    parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          source_byte,
    input  wire logic                final_byte,
    output stl_pkg::result_set_t     results
);

    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] MAX_POS = {PB{1'b1}};

    typedef struct packed {
        stl_pkg::mode_t    mode;
        logic [PB-1:0]     start;
        stl_pkg::token_t   tok;
        logic              v;
    } idle_res_t;

    stl_pkg::mode_t mode_reg, mode_next;
    logic [PB-1:0]  start_reg, start_next;
    logic [PB-1:0]  pos_reg, pos_next;

    function automatic logic [15:0] lo16(input logic [PB-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return w[15:0];
    endfunction

    function automatic stl_pkg::token_t make_tok(input logic [4:0] kind,
                                                 input logic [PB-1:0] s,
                                                 input logic [PB-1:0] e,
                                                 input logic [2:0] err);
        stl_pkg::token_t t;
        t.token_kind = kind;
        t.start_pos  = lo16(s);
        t.end_pos    = lo16(e);
        t.error_code = err;
        t.run_last   = 1'b0;
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= stl_pkg::CH_0) && (c <= stl_pkg::CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= stl_pkg::CH_LOWER_A) && (c <= stl_pkg::CH_LOWER_Z)) ||
               ((c >= stl_pkg::CH_UPPER_A) && (c <= stl_pkg::CH_UPPER_Z));
    endfunction

    // start of a fresh token at position p
    function automatic idle_res_t scan_idle(input logic [7:0] c, input logic [PB-1:0] p);
        idle_res_t r;
        logic [PB-1:0] p1;
        p1      = p + 1'b1;
        r.mode  = stl_pkg::MODE_IDLE;
        r.start = p;
        r.tok   = make_tok(stl_pkg::K_PLUS, p, p1, stl_pkg::ERR_NONE);
        r.v     = 1'b0;
        unique case (c) inside
            stl_pkg::CH_SPACE, stl_pkg::CH_TAB, stl_pkg::CH_CR: ;
            stl_pkg::CH_HASH:  r.mode = stl_pkg::MODE_COMMENT;
            stl_pkg::CH_PLUS:  r.v = 1'b1;
            stl_pkg::CH_MINUS:
            begin
                r.tok = make_tok(stl_pkg::K_MINUS, p, p1, stl_pkg::ERR_NONE);
                r.v   = 1'b1;
            end
            stl_pkg::CH_STAR:
            begin
                r.tok = make_tok(stl_pkg::K_STAR, p, p1, stl_pkg::ERR_NONE);
                r.v   = 1'b1;
            end
            stl_pkg::CH_SLASH:
            begin
                r.tok = make_tok(stl_pkg::K_SLASH, p, p1, stl_pkg::ERR_NONE);
                r.v   = 1'b1;
            end
            stl_pkg::CH_NL:
            begin
                r.tok = make_tok(stl_pkg::K_NEWLINE, p, p1, stl_pkg::ERR_NONE);
                r.v   = 1'b1;
            end
            stl_pkg::CH_EQ:    r.mode = stl_pkg::MODE_EQ;
            stl_pkg::CH_GT:    r.mode = stl_pkg::MODE_GT;
            stl_pkg::CH_LT:    r.mode = stl_pkg::MODE_LT;
            stl_pkg::CH_BANG:  r.mode = stl_pkg::MODE_BANG;
            stl_pkg::CH_QUOTE:
            begin
                r.start = p1;
                r.mode  = stl_pkg::MODE_STRING;
            end
            [stl_pkg::CH_0:stl_pkg::CH_9]: r.mode = stl_pkg::MODE_INT;
            [stl_pkg::CH_UPPER_A:stl_pkg::CH_UPPER_Z],
            [stl_pkg::CH_LOWER_A:stl_pkg::CH_LOWER_Z]: r.mode = stl_pkg::MODE_IDENT;
            default:
            begin
                r.tok  = make_tok(stl_pkg::K_ERROR, p, p1, stl_pkg::ERR_UNKNOWN);
                r.v    = 1'b1;
                r.mode = stl_pkg::MODE_DRAIN;
            end
        endcase
        return r;
    endfunction

    idle_res_t       idle;
    stl_pkg::mode_t  mode_f, fin_mode;
    logic [PB-1:0]   start_f, fin_start, fin_pos, p, p1;
    stl_pkg::token_t list [4];
    logic [3:0]      list_v;
    logic            do_fin, stay_feed;
    logic [1:0]      n;

    always_comb
    begin
        p    = pos_reg;
        p1   = pos_reg + 1'b1;
        idle = scan_idle(source_byte, p);

        // feed a normal byte
        mode_f    = mode_reg;
        start_f   = start_reg;
        stay_feed = 1'b0;
        list[0]   = idle.tok;
        list[1]   = idle.tok;
        list_v    = 4'b0000;

        unique case (mode_reg)
            stl_pkg::MODE_IDLE:
            begin
                mode_f    = idle.mode;
                start_f   = idle.start;
                list_v[0] = idle.v;
            end
            stl_pkg::MODE_COMMENT:
            begin
                if (source_byte == stl_pkg::CH_NL)
                begin
                    mode_f    = idle.mode;
                    start_f   = idle.start;
                    list_v[0] = idle.v;
                end
            end
            stl_pkg::MODE_EQ, stl_pkg::MODE_GT, stl_pkg::MODE_LT:
            begin
                if (source_byte == stl_pkg::CH_EQ)
                begin
                    list[0] = make_tok(mode_reg == stl_pkg::MODE_EQ ? stl_pkg::K_EQEQ :
                                       mode_reg == stl_pkg::MODE_GT ? stl_pkg::K_GTEQ :
                                       stl_pkg::K_LTEQ, start_reg, p1, stl_pkg::ERR_NONE);
                    list_v[0] = 1'b1;
                    mode_f    = stl_pkg::MODE_IDLE;
                end
                else
                begin
                    list[0] = make_tok(mode_reg == stl_pkg::MODE_EQ ? stl_pkg::K_EQ :
                                       mode_reg == stl_pkg::MODE_GT ? stl_pkg::K_GT :
                                       stl_pkg::K_LT, start_reg, start_reg + 1'b1,
                                       stl_pkg::ERR_NONE);
                    list_v[0] = 1'b1;
                    stay_feed = 1'b1;
                end
            end
            stl_pkg::MODE_BANG:
            begin
                list_v[0] = 1'b1;
                if (source_byte == stl_pkg::CH_EQ)
                begin
                    list[0] = make_tok(stl_pkg::K_NOTEQ, start_reg, p1, stl_pkg::ERR_NONE);
                    mode_f  = stl_pkg::MODE_IDLE;
                end
                else
                begin
                    list[0] = make_tok(stl_pkg::K_ERROR, start_reg, p1, stl_pkg::ERR_UNKNOWN);
                    mode_f  = stl_pkg::MODE_DRAIN;
                end
            end
            stl_pkg::MODE_INT:
            begin
                if (source_byte == stl_pkg::CH_DOT)
                    mode_f = stl_pkg::MODE_DOT;
                else if (!is_digit(source_byte))
                begin
                    list[0]   = make_tok(stl_pkg::K_NUMBER, start_reg, p, stl_pkg::ERR_NONE);
                    list_v[0] = 1'b1;
                    stay_feed = 1'b1;
                end
            end
            stl_pkg::MODE_DOT:
            begin
                if (is_digit(source_byte))
                    mode_f = stl_pkg::MODE_FRAC;
                else
                begin
                    list[0]   = make_tok(stl_pkg::K_ERROR, start_reg, p1,
                                         stl_pkg::ERR_BAD_NUM);
                    list_v[0] = 1'b1;
                    mode_f    = stl_pkg::MODE_DRAIN;
                end
            end
            stl_pkg::MODE_FRAC:
            begin
                if (!is_digit(source_byte))
                begin
                    list[0]   = make_tok(stl_pkg::K_NUMBER, start_reg, p, stl_pkg::ERR_NONE);
                    list_v[0] = 1'b1;
                    stay_feed = 1'b1;
                end
            end
            stl_pkg::MODE_IDENT:
            begin
                if (!is_digit(source_byte) && !is_alpha(source_byte))
                begin
                    list[0]   = make_tok(stl_pkg::K_IDENT, start_reg, p, stl_pkg::ERR_NONE);
                    list_v[0] = 1'b1;
                    stay_feed = 1'b1;
                end
            end
            stl_pkg::MODE_STRING:
            begin
                if (source_byte == stl_pkg::CH_QUOTE)
                begin
                    list[0]   = make_tok(stl_pkg::K_STRING, start_reg, p, stl_pkg::ERR_NONE);
                    list_v[0] = 1'b1;
                    mode_f    = stl_pkg::MODE_IDLE;
                end
                else if (source_byte == stl_pkg::CH_CR || source_byte == stl_pkg::CH_NL ||
                         source_byte == stl_pkg::CH_TAB ||
                         source_byte == stl_pkg::CH_BACKSLASH ||
                         source_byte == stl_pkg::CH_PERCENT)
                begin
                    list[0]   = make_tok(stl_pkg::K_ERROR, start_reg, p1,
                                         stl_pkg::ERR_BAD_STR);
                    list_v[0] = 1'b1;
                    mode_f    = stl_pkg::MODE_DRAIN;
                end
            end
            stl_pkg::MODE_DRAIN: ;
            default: ;
        endcase

        // token closed by this byte, then the byte itself starts afresh
        if (stay_feed)
        begin
            list[1]   = idle.tok;
            list_v[1] = idle.v;
            mode_f    = idle.mode;
            start_f   = idle.start;
        end

        // pick the path for this byte
        fin_mode  = mode_f;
        fin_start = start_f;
        fin_pos   = p1;
        do_fin    = final_byte;
        pos_next  = final_byte ? '0 : p1;
        if (source_byte == stl_pkg::CH_NUL)
        begin
            fin_mode  = mode_reg;
            fin_start = start_reg;
            fin_pos   = p;
            do_fin    = 1'b1;
            list_v[1:0] = 2'b00;
            pos_next  = '0;
        end
        else if (pos_reg == MAX_POS)
        begin
            list[0]     = make_tok(stl_pkg::K_ERROR, MAX_POS, MAX_POS, stl_pkg::ERR_TOO_LONG);
            list_v[0]   = (mode_reg != stl_pkg::MODE_DRAIN);
            list_v[1]   = 1'b0;
            fin_mode    = stl_pkg::MODE_DRAIN;
            fin_start   = start_reg;
            fin_pos     = MAX_POS;
            pos_next    = final_byte ? '0 : MAX_POS;
        end

        // end of source: flush the pending token, then END
        list[2] = make_tok(stl_pkg::K_EQ, fin_start, fin_start + 1'b1, stl_pkg::ERR_NONE);
        unique case (fin_mode)
            stl_pkg::MODE_EQ:  list_v[2] = do_fin;
            stl_pkg::MODE_GT:
            begin
                list[2].token_kind = stl_pkg::K_GT;
                list_v[2]          = do_fin;
            end
            stl_pkg::MODE_LT:
            begin
                list[2].token_kind = stl_pkg::K_LT;
                list_v[2]          = do_fin;
            end
            stl_pkg::MODE_BANG:
            begin
                list[2]   = make_tok(stl_pkg::K_ERROR, fin_start, fin_pos, stl_pkg::ERR_UNKNOWN);
                list_v[2] = do_fin;
            end
            stl_pkg::MODE_INT, stl_pkg::MODE_FRAC:
            begin
                list[2]   = make_tok(stl_pkg::K_NUMBER, fin_start, fin_pos, stl_pkg::ERR_NONE);
                list_v[2] = do_fin;
            end
            stl_pkg::MODE_DOT:
            begin
                list[2]   = make_tok(stl_pkg::K_ERROR, fin_start, fin_pos, stl_pkg::ERR_BAD_NUM);
                list_v[2] = do_fin;
            end
            stl_pkg::MODE_IDENT:
            begin
                list[2]   = make_tok(stl_pkg::K_IDENT, fin_start, fin_pos, stl_pkg::ERR_NONE);
                list_v[2] = do_fin;
            end
            stl_pkg::MODE_STRING:
            begin
                list[2]   = make_tok(stl_pkg::K_ERROR, fin_start, fin_pos, stl_pkg::ERR_UNTERM);
                list_v[2] = do_fin;
            end
            default:   list_v[2] = 1'b0;
        endcase
        list[3]   = make_tok(stl_pkg::K_END, fin_pos, fin_pos, stl_pkg::ERR_NONE);
        list_v[3] = do_fin;

        mode_next  = do_fin ? stl_pkg::MODE_IDLE : fin_mode;
        start_next = do_fin ? '0 : fin_start;

        // pack the valid tokens into the front slots
        results.tok = '0;
        n = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (list_v[i] && (n != 2'd3))
            begin
                results.tok[n] = list[i];
                n = n + 2'd1;
            end
        end
        if (n != 2'd0)
            results.tok[n - 2'd1].run_last = 1'b1;
        results.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stl_pkg::MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stl_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stl_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire stl_pkg::result_set_t results,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output stl_pkg::token_t           out_tok,
    output logic                      room
);

    localparam int DEPTH = stl_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    stl_pkg::token_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] push_n;
    logic [PTR_W-1:0] tail;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[head_reg];
    assign pop       = out_valid && out_ready;
    // a whole byte's worth of tokens must fit
    assign room      = (count_reg <= CNT_W'(DEPTH - stl_pkg::MAX_RESULTS));
    assign push_n    = push ? CNT_W'(results.count) : '0;
    assign tail      = head_reg + count_reg[PTR_W-1:0];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < stl_pkg::MAX_RESULTS; i++)
        begin
            if (push && (2'(i) < results.count))
                mem_reg[tail + PTR_W'(i)] <= results.tok[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
                head_reg <= head_reg + 1'b1;
            count_reg <= count_reg + push_n - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/source_text_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokeniser: one source byte per transaction in, tokens out as kind,
// start and end position (end exclusive, low 16 bits) with an error code. A
// byte is taken every cycle as long as each byte yields at most one token and
// m_tready is high; a byte can yield up to three tokens, as when it closes a
// token and ends the source, which the four-entry result queue absorbs (input
// is taken while three slots are free). Tokens of one byte leave in order, the
// last of them flagged by m_tlast. A byte's tokens are queued when it is taken.
// A zero byte or s_tlast ends the source with END and restarts at position 0;
// after an error the rest of the source is dropped. No pass after reset is
// needed.
module source_text_tokenizer #(
    parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,  // [7:0] source_byte
    input  wire logic                         s_tlast,  // final_byte
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [15:0] start_pos, [31:16] end_pos, [34:32] error_code, [39:35] zero
    output logic [stl_pkg::TDATA_W-1:0]       m_tdata,
    output logic [4:0]                        m_tuser,  // [4:0] token_kind
    output logic                              m_tlast   // run_last
);

`include "source_text_tokenizer_defines.svh"

    stl_pkg::result_set_t results;
    stl_pkg::token_t      out_tok;
    logic                 accept;

    assign accept = s_tvalid && s_tready;

    stl_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .source_byte (s_tdata),
        .final_byte  (s_tlast),
        .results     (results)
    );

    stl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .results   (results),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_tok   (out_tok),
        .room      (s_tready)
    );

    assign m_tdata = {5'b0, out_tok.error_code, out_tok.end_pos, out_tok.start_pos};
    assign m_tuser = out_tok.token_kind;
    assign m_tlast = out_tok.run_last;

    // END always closes the tokens of its byte and spans nothing
    `STL_ASSERT_IMPLIES(a_end_last, m_tvalid && (m_tuser == stl_pkg::K_END), m_tlast)
    `STL_ASSERT_IMPLIES(a_end_empty, m_tvalid && (m_tuser == stl_pkg::K_END), m_tdata[15:0] == m_tdata[31:16])
    `STL_ASSERT_IMPLIES(a_err_only_on_error, m_tvalid && (m_tuser != stl_pkg::K_ERROR), m_tdata[34:32] == stl_pkg::ERR_NONE)
    // a zero byte always queues END
    `STL_ASSERT_NEXT(a_nul_gives_result, accept && (s_tdata == stl_pkg::CH_NUL), m_tvalid)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic [15:0] LAST_POS = 16'hFFFF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } src_byte_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata = '0;
    logic                        s_tlast = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [stl_pkg::TDATA_W-1:0] m_tdata;
    logic [4:0]                  m_tuser;
    logic                        m_tlast;

    src_byte_t       source_queue[$];
    stl_pkg::token_t token_queue[$];
    stl_pkg::token_t byte_tokens[$];

    int gap_pct = 0;
    int stall_pct = 0;
    int bytes_queued = 0;
    int bytes_offered = 0;
    int bytes_taken = 0;
    int mismatch_count = 0;

    // scanner state of the predictor
    stl_pkg::mode_t scan_state = stl_pkg::MODE_IDLE;
    logic [15:0]    tok_start = '0;
    logic [15:0]    byte_pos = '0;

    source_text_tokenizer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    function automatic bit digit_char(input logic [7:0] c);
        return c >= stl_pkg::CH_0 && c <= stl_pkg::CH_9;
    endfunction

    function automatic bit alpha_char(input logic [7:0] c);
        return (c >= stl_pkg::CH_LOWER_A && c <= stl_pkg::CH_LOWER_Z) ||
               (c >= stl_pkg::CH_UPPER_A && c <= stl_pkg::CH_UPPER_Z);
    endfunction

    task automatic emit(input logic [4:0] kind, input logic [15:0] s, input logic [15:0] e,
                        input logic [2:0] err);
        stl_pkg::token_t t;
        if (byte_tokens.size() < stl_pkg::MAX_RESULTS)
        begin
            t.token_kind = kind;
            t.start_pos  = s;
            t.end_pos    = e;
            t.error_code = err;
            t.run_last   = 1'b0;
            byte_tokens.push_back(t);
        end
    endtask

    task automatic raise_error(input logic [2:0] err, input logic [15:0] s,
                               input logic [15:0] e);
        emit(stl_pkg::K_ERROR, s, e, err);
        scan_state = stl_pkg::MODE_DRAIN;
    endtask

    task automatic start_token(input logic [7:0] c, input logic [15:0] p);
        scan_state = stl_pkg::MODE_IDLE;
        tok_start = p;
        case (c)
            stl_pkg::CH_SPACE, stl_pkg::CH_TAB, stl_pkg::CH_CR: ;
            stl_pkg::CH_HASH:  scan_state = stl_pkg::MODE_COMMENT;
            stl_pkg::CH_PLUS:  emit(stl_pkg::K_PLUS, p, p + 16'd1, stl_pkg::ERR_NONE);
            stl_pkg::CH_MINUS: emit(stl_pkg::K_MINUS, p, p + 16'd1, stl_pkg::ERR_NONE);
            stl_pkg::CH_STAR:  emit(stl_pkg::K_STAR, p, p + 16'd1, stl_pkg::ERR_NONE);
            stl_pkg::CH_SLASH: emit(stl_pkg::K_SLASH, p, p + 16'd1, stl_pkg::ERR_NONE);
            stl_pkg::CH_NL:    emit(stl_pkg::K_NEWLINE, p, p + 16'd1, stl_pkg::ERR_NONE);
            stl_pkg::CH_EQ:    scan_state = stl_pkg::MODE_EQ;
            stl_pkg::CH_GT:    scan_state = stl_pkg::MODE_GT;
            stl_pkg::CH_LT:    scan_state = stl_pkg::MODE_LT;
            stl_pkg::CH_BANG:  scan_state = stl_pkg::MODE_BANG;
            stl_pkg::CH_QUOTE:
            begin
                tok_start = p + 16'd1;
                scan_state = stl_pkg::MODE_STRING;
            end
            default:
            begin
                if (digit_char(c))
                    scan_state = stl_pkg::MODE_INT;
                else if (alpha_char(c))
                    scan_state = stl_pkg::MODE_IDENT;
                else
                    raise_error(stl_pkg::ERR_UNKNOWN, p, p + 16'd1);
            end
        endcase
    endtask

    // one-char lookahead for = > <
    task automatic close_pair(input logic [7:0] c, input logic [15:0] p,
                              input logic [4:0] two, input logic [4:0] one);
        if (c == stl_pkg::CH_EQ)
        begin
            emit(two, tok_start, p + 16'd1, stl_pkg::ERR_NONE);
            scan_state = stl_pkg::MODE_IDLE;
        end
        else
        begin
            emit(one, tok_start, tok_start + 16'd1, stl_pkg::ERR_NONE);
            start_token(c, p);
        end
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic [15:0] p);
        case (scan_state)
            stl_pkg::MODE_IDLE:    start_token(c, p);
            stl_pkg::MODE_COMMENT: if (c == stl_pkg::CH_NL) start_token(c, p);
            stl_pkg::MODE_EQ:      close_pair(c, p, stl_pkg::K_EQEQ, stl_pkg::K_EQ);
            stl_pkg::MODE_GT:      close_pair(c, p, stl_pkg::K_GTEQ, stl_pkg::K_GT);
            stl_pkg::MODE_LT:      close_pair(c, p, stl_pkg::K_LTEQ, stl_pkg::K_LT);
            stl_pkg::MODE_BANG:
            begin
                if (c == stl_pkg::CH_EQ)
                begin
                    emit(stl_pkg::K_NOTEQ, tok_start, p + 16'd1, stl_pkg::ERR_NONE);
                    scan_state = stl_pkg::MODE_IDLE;
                end
                else
                    raise_error(stl_pkg::ERR_UNKNOWN, tok_start, p + 16'd1);
            end
            stl_pkg::MODE_INT:
            begin
                if (c == stl_pkg::CH_DOT)
                    scan_state = stl_pkg::MODE_DOT;
                else if (!digit_char(c))
                begin
                    emit(stl_pkg::K_NUMBER, tok_start, p, stl_pkg::ERR_NONE);
                    start_token(c, p);
                end
            end
            stl_pkg::MODE_DOT:
            begin
                if (digit_char(c))
                    scan_state = stl_pkg::MODE_FRAC;
                else
                    raise_error(stl_pkg::ERR_BAD_NUM, tok_start, p + 16'd1);
            end
            stl_pkg::MODE_FRAC:
            begin
                if (!digit_char(c))
                begin
                    emit(stl_pkg::K_NUMBER, tok_start, p, stl_pkg::ERR_NONE);
                    start_token(c, p);
                end
            end
            stl_pkg::MODE_IDENT:
            begin
                if (!digit_char(c) && !alpha_char(c))
                begin
                    emit(stl_pkg::K_IDENT, tok_start, p, stl_pkg::ERR_NONE);
                    start_token(c, p);
                end
            end
            stl_pkg::MODE_STRING:
            begin
                if (c == stl_pkg::CH_QUOTE)
                begin
                    emit(stl_pkg::K_STRING, tok_start, p, stl_pkg::ERR_NONE);
                    scan_state = stl_pkg::MODE_IDLE;
                end
                else if (c == stl_pkg::CH_CR || c == stl_pkg::CH_NL ||
                         c == stl_pkg::CH_TAB || c == stl_pkg::CH_BACKSLASH ||
                         c == stl_pkg::CH_PERCENT)
                    raise_error(stl_pkg::ERR_BAD_STR, tok_start, p + 16'd1);
            end
            default: ;
        endcase
    endtask

    task automatic end_source(input logic [15:0] e);
        case (scan_state)
            stl_pkg::MODE_EQ:
                emit(stl_pkg::K_EQ, tok_start, tok_start + 16'd1, stl_pkg::ERR_NONE);
            stl_pkg::MODE_GT:
                emit(stl_pkg::K_GT, tok_start, tok_start + 16'd1, stl_pkg::ERR_NONE);
            stl_pkg::MODE_LT:
                emit(stl_pkg::K_LT, tok_start, tok_start + 16'd1, stl_pkg::ERR_NONE);
            stl_pkg::MODE_BANG:
                emit(stl_pkg::K_ERROR, tok_start, e, stl_pkg::ERR_UNKNOWN);
            stl_pkg::MODE_INT, stl_pkg::MODE_FRAC:
                emit(stl_pkg::K_NUMBER, tok_start, e, stl_pkg::ERR_NONE);
            stl_pkg::MODE_DOT:
                emit(stl_pkg::K_ERROR, tok_start, e, stl_pkg::ERR_BAD_NUM);
            stl_pkg::MODE_IDENT:
                emit(stl_pkg::K_IDENT, tok_start, e, stl_pkg::ERR_NONE);
            stl_pkg::MODE_STRING:
                emit(stl_pkg::K_ERROR, tok_start, e, stl_pkg::ERR_UNTERM);
            default: ;
        endcase
        emit(stl_pkg::K_END, e, e, stl_pkg::ERR_NONE);
        scan_state = stl_pkg::MODE_IDLE;
        tok_start = '0;
        byte_pos = '0;
    endtask

    // tokens expected from one accepted byte, appended to token_queue
    task automatic tokenize_byte(input logic [7:0] c, input logic fin);
        logic [15:0] p;
        p = byte_pos;
        byte_tokens.delete();
        if (c == stl_pkg::CH_NUL)
            end_source(p);
        else if (p == LAST_POS)
        begin
            if (scan_state != stl_pkg::MODE_DRAIN)
                raise_error(stl_pkg::ERR_TOO_LONG, LAST_POS, LAST_POS);
            if (fin)
                end_source(LAST_POS);
        end
        else
        begin
            scan_byte(c, p);
            byte_pos = p + 16'd1;
            if (fin)
                end_source(p + 16'd1);
        end
        if (byte_tokens.size() != 0)
            byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
        foreach (byte_tokens[i])
            token_queue.push_back(byte_tokens[i]);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // monitor and predictor
    always @(posedge clk)
    begin
        stl_pkg::token_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (token_queue.size() == 0)
                begin
                    $error("token_kind: expected none, got %0d", m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = token_queue.pop_front();
                    check_field("token_kind", want.token_kind, m_tuser);
                    check_field("start_pos", want.start_pos, m_tdata[15:0]);
                    check_field("end_pos", want.end_pos, m_tdata[31:16]);
                    check_field("error_code", want.error_code, m_tdata[34:32]);
                    check_field("tdata padding", 0, m_tdata[stl_pkg::TDATA_W-1:35]);
                    check_field("run_last", want.run_last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
            begin
                tokenize_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
        end
    end

    // byte driver and sink back-pressure
    always @(negedge clk)
    begin
        src_byte_t item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
            if (!(s_tvalid && bytes_taken < bytes_offered))
            begin
                if (source_queue.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    item = source_queue.pop_front();
                    s_tdata <= item.ch;
                    s_tlast <= item.last;
                    s_tvalid <= 1'b1;
                    bytes_offered++;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic push_char(input logic [7:0] c, input logic fin = 1'b0);
        src_byte_t item;
        item.ch = c;
        item.last = fin;
        source_queue.push_back(item);
        bytes_queued++;
    endtask

    task automatic push_text(input string text, input logic flag_last);
        for (int i = 0; i < text.len(); i++)
            push_char(text[i], flag_last && (i == text.len() - 1));
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1))
            return 8'($urandom_range(stl_pkg::CH_LOWER_A, stl_pkg::CH_LOWER_Z));
        return 8'($urandom_range(stl_pkg::CH_UPPER_A, stl_pkg::CH_UPPER_Z));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'($urandom_range(stl_pkg::CH_0, stl_pkg::CH_9));
    endfunction

    function automatic logic [7:0] string_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == stl_pkg::CH_QUOTE || c == stl_pkg::CH_BACKSLASH ||
               c == stl_pkg::CH_PERCENT)
            c = 8'($urandom_range(8'h20, 8'h7E));
        return c;
    endfunction

    // one source: mostly well-formed lexemes, some noise and broken ones
    task automatic add_source();
        logic [7:0] pair_ops[4];
        logic [7:0] single_ops[4];
        logic [7:0] blanks[3];
        logic [7:0] bad_str[5];
        int count;
        pair_ops   = '{stl_pkg::CH_EQ, stl_pkg::CH_GT, stl_pkg::CH_LT, stl_pkg::CH_BANG};
        single_ops = '{stl_pkg::CH_PLUS, stl_pkg::CH_MINUS, stl_pkg::CH_STAR,
                       stl_pkg::CH_SLASH};
        blanks     = '{stl_pkg::CH_SPACE, stl_pkg::CH_TAB, stl_pkg::CH_CR};
        bad_str    = '{stl_pkg::CH_TAB, stl_pkg::CH_CR, stl_pkg::CH_NL,
                       stl_pkg::CH_BACKSLASH, stl_pkg::CH_PERCENT};
        count = $urandom_range(1, 8);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(17))
                0, 12, 13:
                begin
                    push_char(random_letter());
                    repeat ($urandom_range(3))
                        push_char($urandom_range(1) ? random_letter() : random_digit());
                end
                1, 14:
                begin
                    repeat ($urandom_range(1, 3)) push_char(random_digit());
                    if ($urandom_range(1))
                    begin
                        push_char(stl_pkg::CH_DOT);
                        repeat ($urandom_range(1, 2)) push_char(random_digit());
                    end
                end
                2:
                begin
                    push_char(stl_pkg::CH_QUOTE);
                    repeat ($urandom_range(4)) push_char(string_char());
                    push_char(stl_pkg::CH_QUOTE);
                end
                3:     push_char(single_ops[$urandom_range(3)]);
                4, 15:
                begin
                    push_char(pair_ops[$urandom_range(3)]);
                    if ($urandom_range(1))
                        push_char(stl_pkg::CH_EQ);
                end
                5, 16: push_char(blanks[$urandom_range(2)]);
                6:     push_char(stl_pkg::CH_NL);
                7:
                begin
                    push_char(stl_pkg::CH_HASH);
                    repeat ($urandom_range(5)) push_char(8'($urandom_range(1, 255)));
                    push_char(stl_pkg::CH_NL);
                end
                8:     push_char(8'($urandom_range(1, 255)));
                9:
                begin
                    push_char(random_digit());
                    push_char(stl_pkg::CH_DOT);
                    push_char(random_letter());
                end
                10:
                begin
                    push_char(stl_pkg::CH_QUOTE);
                    push_char(string_char());
                    push_char(bad_str[$urandom_range(4)]);
                end
                11:
                begin
                    push_char(stl_pkg::CH_QUOTE);
                    repeat ($urandom_range(3)) push_char(random_letter());
                end
                default:
                begin
                    push_char(stl_pkg::CH_SPACE);
                    push_char(random_letter());
                end
            endcase
        end
        case ($urandom_range(2))
            0: push_char(stl_pkg::CH_NUL);
            1: source_queue[source_queue.size() - 1].last = 1'b1;
            default: push_char(stl_pkg::CH_NUL, 1'b1);
        endcase
    endtask

    task automatic wait_sent();
        while (source_queue.size() != 0 || bytes_taken < bytes_offered)
            @(posedge clk);
    endtask

    initial
    begin
        gap_pct = 6;
        stall_pct = 64;

        // directed: + - * / = > <, lone lookahead at end, unknown, bad string and bad number errors
        push_text("+-*/\n", 1'b0);
        push_char(stl_pkg::CH_NUL);
        push_text("x=1>2<", 1'b1);
        push_text("\"a%", 1'b1);
        push_char(8'hFF, 1'b1);
        push_text("1.", 1'b0);
        push_char(stl_pkg::CH_NUL);
        push_char(stl_pkg::CH_BANG);
        push_char(stl_pkg::CH_NUL, 1'b1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_queued < 170)
            add_source();
        wait_sent();

        gap_pct = 64;
        stall_pct = 6;
        while (bytes_queued < 320)
            add_source();
        wait_sent();

        gap_pct = 0;
        stall_pct = 0;
        while (bytes_queued < 470)
            add_source();
        wait_sent();

        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== source_text_tokenizer.f =====
+incdir+rtl
rtl/stl_pkg.sv
rtl/stl_scan.sv
rtl/stl_fifo.sv
rtl/source_text_tokenizer.sv
sim/tb.sv
